// File: rtl/mbc_pkg.sv
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared types, codes and helpers of the maze backtrack carver.
// ----------------------------------------------------------------------------
package mbc_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_LOAD,
    ST_TRY,
    ST_CHECK,
    ST_OPEN_WALL,
    ST_OPEN_CELL,
    ST_EMIT_WALL,
    ST_EMIT_CELL,
    ST_EMIT_FIN
  } mbc_state_t;

  // Result kinds (out_tuser)
  localparam logic [1:0] EV_CELL   = 2'd0;
  localparam logic [1:0] EV_WALL   = 2'd1;
  localparam logic [1:0] EV_FINISH = 2'd2;

  // Input actions (in_tuser)
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_START_X     = 2'd2;
  localparam logic [1:0] CFG_START_Y     = 2'd3;

  // Direction codes
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Wall map operations for one cycle
  typedef struct packed {
    logic clr_row;    // set a whole row to walls
    logic open_cell;  // clear one bit (make it a passage)
    logic rd;         // read one row, select one bit
  } map_op_t;

  // Shuffle N,E,S,W from four 2-bit draws; order[k] sits in bits [2k+1:2k]
  function automatic logic [7:0] shuffle_order(input logic [7:0] draws);
    logic [3:0][1:0] ord;
    logic [1:0]      r;
    logic [1:0]      t;
    ord = {DIR_W, DIR_S, DIR_E, DIR_N};
    for (int i = 0; i < 4; i++) begin
      r      = draws[2*i +: 2];
      t      = ord[r];
      ord[r] = ord[i];
      ord[i] = t;
    end
    return ord;
  endfunction

endpackage

// File: rtl/mbc_wall_map.sv
// ----------------------------------------------------------------------------
// mbc_wall_map
// Wall/passage bit grid, one row per memory word; row clear, bit clear and a
// registered row read with bit select.
// ----------------------------------------------------------------------------
module mbc_wall_map
  import mbc_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 32,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic          clk,
  input  map_op_t       op,
  input  logic [RW-1:0] wr_row,
  input  logic [XW-1:0] wr_col,
  input  logic [RW-1:0] rd_row,
  input  logic [XW-1:0] rd_col,
  output logic          rd_wall
);

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_data_r;
  logic [XW-1:0]        rd_col_r;

  // Single write port: whole row to walls, or one bit to passage
  always_ff @(posedge clk) begin
    if (op.clr_row) begin
      mem[wr_row] <= '1;
    end else if (op.open_cell) begin
      mem[wr_row][wr_col] <= 1'b0;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (op.rd) begin
      rd_data_r <= mem[rd_row];
      rd_col_r  <= rd_col;
    end
  end

  assign rd_wall = rd_data_r[rd_col_r];

endmodule

// File: rtl/mbc_frame_stack.sv
// ----------------------------------------------------------------------------
// mbc_frame_stack
// Frame memory of the depth-first search: one write and one registered read
// port.
// ----------------------------------------------------------------------------
module mbc_frame_stack
  import mbc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int FW    = 23,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [FW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [FW-1:0] rdata
);

  logic [FW-1:0] mem [DEPTH];
  logic [FW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/maze_backtrack_carver_unit.sv
// ----------------------------------------------------------------------------
// maze_backtrack_carver_unit
// Randomized depth-first maze carver with an explicit frame stack in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects the action (0 start a maze, 1 carve one
//   move), in_tdata carries four 2-bit draws that shuffle the direction
//   order of a newly entered cell. Result stream: out_tdata carries the
//   cell coordinates, out_tuser the kind (cell opened, wall opened,
//   finished), out_tlast marks the final result of an input item.
//   The cfg channel writes grid width/height and the start cell; it is
//   always ready and must only be used while the block is idle.
//   One item is in work at a time. A start clears the wall map, which
//   writes one row per cycle, then opens the start cell if it lies in the
//   grid. A step tries the directions in turn, reads the wall map for each
//   in-bounds neighbor, fetches the next frame from frame memory each time
//   a frame is popped, then emits its results one at a time.
//   After reset the wall map is cleared row by row with in_tready low;
//   the stack starts empty. Results leave through a single output
//   register: while the receiver stalls the sequencer waits before its
//   next emit, and the next item is taken while the last result is still
//   waiting.
// ----------------------------------------------------------------------------
module maze_backtrack_carver_unit
  import mbc_pkg::*;
#(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 32,
  parameter int STACK_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] random_bits
  input  logic        in_tuser,    // [0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [6:0] cell_x, [11:7] cell_y, [15:12] zero
  output logic [1:0]  out_tuser,   // [1:0] event_res
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int FW   = XW + RW + 8 + 3;

  // Configuration registers
  logic [7:0] grid_width_r;
  logic [5:0] grid_height_r;
  logic [6:0] start_x_r;
  logic [4:0] start_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 8'd79;
      grid_height_r <= 6'd23;
      start_x_r     <= 7'd1;
      start_y_r     <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data[5:0];
        CFG_START_X:     start_x_r     <= cfg_data[6:0];
        CFG_START_Y:     start_y_r     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Grid size in use, clamped to the storage
  logic [8:0] used_w;
  logic [8:0] used_h;

  assign used_w = (9'(grid_width_r) > 9'(MAX_WIDTH))   ? 9'(MAX_WIDTH)  : 9'(grid_width_r);
  assign used_h = (9'(grid_height_r) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(grid_height_r);

  // Sequencer and datapath registers
  mbc_state_t      state_r, state_nxt;
  logic [RW-1:0]   clr_row_r, clr_row_nxt;
  logic            clr_start_r, clr_start_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [7:0]      bits_r, bits_nxt;
  logic [XW-1:0]   fx_r, fx_nxt;
  logic [RW-1:0]   fy_r, fy_nxt;
  logic [7:0]      ford_r, ford_nxt;
  logic [2:0]      fnext_r, fnext_nxt;
  logic [XW-1:0]   cx_r, cx_nxt;
  logic [RW-1:0]   cy_r, cy_nxt;
  logic [XW-1:0]   wx_r, wx_nxt;
  logic [RW-1:0]   wy_r, wy_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [6:0]      out_x_r, out_x_nxt;
  logic [4:0]      out_y_r, out_y_nxt;
  logic [1:0]      out_ev_r, out_ev_nxt;
  logic            out_last_r, out_last_nxt;

  // Memory ports
  map_op_t         map_op;
  logic [RW-1:0]   map_wr_row;
  logic [XW-1:0]   map_wr_col;
  logic            map_rd_wall;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr;
  logic [FW-1:0]   stk_wdata;
  logic            stk_re;
  logic [FW-1:0]   stk_rdata;
  logic [SAW-1:0]  stk_top;

  // Handshake helpers
  logic in_xfer;
  logic emit_ok;
  logic emit;
  logic start_oob;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign emit_ok   = !out_valid_r || out_tready;
  assign start_oob = (9'(start_x_r) >= used_w) || (9'(start_y_r) >= used_h);
  assign stk_top   = SAW'(cnt_r - CNTW'(1));

  // Candidate neighbor two steps away and the wall cell between
  logic [1:0] dir_cur;
  logic [8:0] cand_x, cand_y, mid_x, mid_y;
  logic       cand_in;

  assign dir_cur = ford_r[{fnext_r[1:0], 1'b0} +: 2];

  always_comb begin
    cand_x = 9'(fx_r);
    cand_y = 9'(fy_r);
    mid_x  = 9'(fx_r);
    mid_y  = 9'(fy_r);
    case (dir_cur)
      DIR_N: begin
        cand_y = 9'(fy_r) - 9'd2;
        mid_y  = 9'(fy_r) - 9'd1;
      end
      DIR_E: begin
        cand_x = 9'(fx_r) + 9'd2;
        mid_x  = 9'(fx_r) + 9'd1;
      end
      DIR_S: begin
        cand_y = 9'(fy_r) + 9'd2;
        mid_y  = 9'(fy_r) + 9'd1;
      end
      default: begin
        cand_x = 9'(fx_r) - 9'd2;
        mid_x  = 9'(fx_r) - 9'd1;
      end
    endcase
  end

  // Underflow wraps to a large value and fails the compare
  assign cand_in = (cand_x < used_w) && (cand_y < used_h);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_row_r == RW'(MAX_HEIGHT - 1)) begin
          state_nxt = clr_start_r ? ST_START : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == ACT_START) begin
            state_nxt = ST_CLEAR;
          end else if (cnt_r == '0) begin
            state_nxt = ST_EMIT_FIN;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_START:     state_nxt = start_oob ? ST_EMIT_FIN : ST_EMIT_CELL;
      ST_FETCH:     state_nxt = ST_LOAD;
      ST_LOAD:      state_nxt = ST_TRY;
      ST_TRY: begin
        if (fnext_r[2]) begin
          state_nxt = (cnt_r == CNTW'(1)) ? ST_EMIT_FIN : ST_FETCH;
        end else if (cand_in) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK:     state_nxt = map_rd_wall ? ST_OPEN_WALL : ST_TRY;
      ST_OPEN_WALL: state_nxt = ST_OPEN_CELL;
      ST_OPEN_CELL: state_nxt = ST_EMIT_WALL;
      ST_EMIT_WALL: if (emit_ok) state_nxt = ST_EMIT_CELL;
      ST_EMIT_CELL: if (emit_ok) state_nxt = ST_IDLE;
      ST_EMIT_FIN:  if (emit_ok) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: memory accesses and datapath updates
  always_comb begin
    map_op        = '0;
    map_wr_row    = cy_r;
    map_wr_col    = cx_r;
    stk_we        = 1'b0;
    stk_waddr     = stk_top;
    stk_wdata     = {fnext_r, ford_r, fy_r, fx_r};
    stk_re        = 1'b0;
    emit          = 1'b0;
    clr_row_nxt   = clr_row_r;
    clr_start_nxt = clr_start_r;
    cnt_nxt       = cnt_r;
    bits_nxt      = bits_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    ford_nxt      = ford_r;
    fnext_nxt     = fnext_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_ev_nxt    = out_ev_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_CLEAR: begin
        map_op.clr_row = 1'b1;
        map_wr_row     = clr_row_r;
        clr_row_nxt    = clr_row_r + RW'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          bits_nxt = in_tdata;
          if (in_tuser == ACT_START) begin
            cnt_nxt       = '0;
            clr_row_nxt   = '0;
            clr_start_nxt = 1'b1;
          end
        end
      end
      ST_START: begin
        if (!start_oob) begin
          map_op.open_cell = 1'b1;
          map_wr_row       = RW'(start_y_r);
          map_wr_col       = XW'(start_x_r);
          stk_we           = 1'b1;
          stk_waddr        = '0;
          stk_wdata        = {3'd0, shuffle_order(bits_r), RW'(start_y_r), XW'(start_x_r)};
          cnt_nxt          = CNTW'(1);
          cx_nxt           = XW'(start_x_r);
          cy_nxt           = RW'(start_y_r);
        end
      end
      ST_FETCH: begin
        stk_re = 1'b1;
      end
      ST_LOAD: begin
        {fnext_nxt, ford_nxt, fy_nxt, fx_nxt} = stk_rdata;
      end
      ST_TRY: begin
        if (fnext_r[2]) begin
          cnt_nxt = cnt_r - CNTW'(1);
        end else begin
          fnext_nxt = fnext_r + 3'd1;
          cx_nxt    = XW'(cand_x);
          cy_nxt    = RW'(cand_y);
          wx_nxt    = XW'(mid_x);
          wy_nxt    = RW'(mid_y);
          map_op.rd = cand_in;
        end
      end
      ST_OPEN_WALL: begin
        // open the wall cell and write back the top frame's progress
        map_op.open_cell = 1'b1;
        map_wr_row       = wy_r;
        map_wr_col       = wx_r;
        stk_we           = 1'b1;
      end
      ST_OPEN_CELL: begin
        map_op.open_cell = 1'b1;
        if (cnt_r < CNTW'(STACK_DEPTH)) begin
          stk_we    = 1'b1;
          stk_waddr = SAW'(cnt_r);
          stk_wdata = {3'd0, shuffle_order(bits_r), cy_r, cx_r};
          cnt_nxt   = cnt_r + CNTW'(1);
        end
      end
      ST_EMIT_WALL: begin
        emit         = emit_ok;
        out_x_nxt    = 7'(wx_r);
        out_y_nxt    = 5'(wy_r);
        out_ev_nxt   = EV_WALL;
        out_last_nxt = 1'b0;
      end
      ST_EMIT_CELL: begin
        emit         = emit_ok;
        out_x_nxt    = 7'(cx_r);
        out_y_nxt    = 5'(cy_r);
        out_ev_nxt   = EV_CELL;
        out_last_nxt = 1'b1;
      end
      ST_EMIT_FIN: begin
        emit         = emit_ok;
        out_x_nxt    = '0;
        out_y_nxt    = '0;
        out_ev_nxt   = EV_FINISH;
        out_last_nxt = 1'b1;
      end
      default: ;
    endcase
    if (!emit) begin
      out_x_nxt    = out_x_r;
      out_y_nxt    = out_y_r;
      out_ev_nxt   = out_ev_r;
      out_last_nxt = out_last_r;
    end
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      clr_start_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      clr_start_r <= clr_start_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bits_r     <= bits_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    ford_r     <= ford_nxt;
    fnext_r    <= fnext_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    wx_r       <= wx_nxt;
    wy_r       <= wy_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_y_r, out_x_r};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

  // Memories
  mbc_wall_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_wall_map (
    .clk     (clk),
    .op      (map_op),
    .wr_row  (map_wr_row),
    .wr_col  (map_wr_col),
    .rd_row  (cy_nxt),
    .rd_col  (cx_nxt),
    .rd_wall (map_rd_wall)
  );

  mbc_frame_stack #(
    .DEPTH (STACK_DEPTH),
    .FW    (FW)
  ) u_frame_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_top),
    .rdata (stk_rdata)
  );

  // Assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(STACK_DEPTH))
    else $error("frame count above stack depth");

  a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_FIN) |-> (cnt_r == '0))
    else $error("finished reported with frames left");

  a_map_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(map_op.rd && (map_op.open_cell || map_op.clr_row)))
    else $error("wall map read and write in one cycle");

  a_stk_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(stk_re && stk_we))
    else $error("frame memory read and write in one cycle");

  a_fetch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (cnt_r != '0))
    else $error("frame fetch on empty stack");

endmodule
